[hw/rtl/yt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yt_pkg
// Shared sizes, types, opcodes and status codes of the Young tableau queue.
// ----------------------------------------------------------------------------
package yt_pkg;

    localparam int ROWS       = 8;
    localparam int COLS       = 8;
    localparam int CELLS      = ROWS * COLS;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLS);
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int KEY_W      = 32;
    localparam int ROW_CMP_W  = ((ROW_W > 3) ? ROW_W : 3) + 1;
    localparam int COL_CMP_W  = ((COL_W > 3) ? COL_W : 3) + 1;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    typedef logic [ROW_W-1:0]         t_row;
    typedef logic [COL_W-1:0]         t_col;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic signed [KEY_W-1:0]  t_key;
    typedef logic [1:0]               t_op;
    typedef logic [1:0]               t_status;

    localparam t_key KEY_EMPTY = 32'sh7FFF_FFFF;
    localparam t_key KEY_MIN   = 32'sh8000_0000;

    localparam t_op OP_INSERT   = 2'd0;
    localparam t_op OP_EXTRACT  = 2'd1;
    localparam t_op OP_CONTAINS = 2'd2;
    localparam t_op OP_DECREASE = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;
    localparam t_status ST_GREATER   = 2'd3;

    localparam t_addr ADDR_FIRST = '0;
    localparam t_addr ADDR_LAST  = ADDR_W'(CELLS - 1);

    function automatic t_addr cell_addr(input t_row r, input t_col c);
        return ADDR_W'(int'(r) * COLS + int'(c));
    endfunction

endpackage

[hw/rtl/yt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yt_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module yt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    output logic [WIDTH-1:0]           o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic [WIDTH-1:0]           o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

[hw/rtl/young_tableau_priority_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// young_tableau_priority_queue_unit
// Young tableau priority queue: insert, extract-min, contains, decrease-key.
// The beat is taken in S_IDLE; each tableau step is a read state followed by
// an evaluate state; the result is posted from S_FIN. Insert and contains
// take up to ROWS+COLS-1 steps; extract and decrease first read the head or
// the target cell. One operation at a time; the next beat is taken once the
// result is posted, and a held result keeps the unit in its final state.
// Reset clears the per-cell valid bits at once; no clearing sweep.
// ----------------------------------------------------------------------------
module young_tableau_priority_queue_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // key[31:0], row[34:32], col[37:35], zero pad
    input  logic [yt_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // opcode[1:0]
    input  logic [yt_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // value[31:0], found[32], status[34:33], is_empty[35], is_full[36], pad
    output logic [yt_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import yt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SU_RD = 4'd1;
    localparam logic [3:0] S_SU_EV = 4'd2;
    localparam logic [3:0] S_X0_RD = 4'd3;
    localparam logic [3:0] S_X0_EV = 4'd4;
    localparam logic [3:0] S_EX_RD = 4'd5;
    localparam logic [3:0] S_EX_EV = 4'd6;
    localparam logic [3:0] S_CT_RD = 4'd7;
    localparam logic [3:0] S_CT_EV = 4'd8;
    localparam logic [3:0] S_DK_RD = 4'd9;
    localparam logic [3:0] S_DK_EV = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]        r_state, n_state;
    t_row              r_row, n_row;
    t_col              r_col, n_col;
    t_key              r_key, n_key;
    t_key              r_value, n_value;
    logic              r_found, n_found;
    t_status           r_status, n_status;

    logic [CELLS-1:0]  r_vld;
    logic              r_va, r_vb;
    logic              r_empty0, r_full;

    logic              r_o_valid;
    t_key              r_o_value;
    logic              r_o_found;
    t_status           r_o_status;
    logic              r_o_empty;
    logic              r_o_full;

    logic              we;
    t_addr             waddr;
    t_key              wdata;
    t_addr             ra_addr, rb_addr;
    logic [KEY_W-1:0]  ra_data, rb_data;
    t_key              qa_k, qb_k;
    t_key              nb_a, nb_b;
    logic              in_acc;
    logic              out_load;
    t_op               in_op;
    t_key              in_key;
    logic [2:0]        in_row, in_col;

    yt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (ra_addr),
        .o_rdata_a (ra_data),
        .i_raddr_b (rb_addr),
        .o_rdata_b (rb_data)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op           = i_s_axis_tuser[1:0];
    assign in_key          = i_s_axis_tdata[31:0];
    assign in_row          = i_s_axis_tdata[34:32];
    assign in_col          = i_s_axis_tdata[37:35];

    // never-written cells read as empty
    assign qa_k = r_va ? t_key'(ra_data) : KEY_EMPTY;
    assign qb_k = r_vb ? t_key'(rb_data) : KEY_EMPTY;

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_key    = r_key;
        n_value  = r_value;
        n_found  = r_found;
        n_status = r_status;
        we       = 1'b0;
        waddr    = cell_addr(r_row, r_col);
        wdata    = r_key;
        ra_addr  = cell_addr(r_row, r_col);
        rb_addr  = cell_addr(r_row, r_col);
        nb_a     = qa_k;
        nb_b     = qb_k;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key    = in_key;
                    n_value  = '0;
                    n_found  = 1'b0;
                    n_status = ST_OK;
                    case (in_op)
                        OP_INSERT: begin
                            if (r_full) begin
                                n_status = ST_OVERFLOW;
                                n_state  = S_FIN;
                            end else begin
                                n_row   = ROW_W'(ROWS - 1);
                                n_col   = COL_W'(COLS - 1);
                                n_state = S_SU_RD;
                            end
                        end
                        OP_EXTRACT: begin
                            if (r_empty0) begin
                                n_status = ST_UNDERFLOW;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_X0_RD;
                            end
                        end
                        OP_CONTAINS: begin
                            n_row   = '0;
                            n_col   = COL_W'(COLS - 1);
                            n_state = (in_key == KEY_EMPTY) ? S_FIN : S_CT_RD;
                        end
                        default: begin
                            if ((ROW_CMP_W'(in_row) < ROW_CMP_W'(ROWS)) &&
                                (COL_CMP_W'(in_col) < COL_CMP_W'(COLS))) begin
                                n_row   = ROW_W'(in_row);
                                n_col   = COL_W'(in_col);
                                n_state = S_DK_RD;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                    endcase
                end
            end
            S_SU_RD: begin
                ra_addr = cell_addr((r_row == '0) ? r_row : r_row - ROW_W'(1), r_col);
                rb_addr = cell_addr(r_row, (r_col == '0) ? r_col : r_col - COL_W'(1));
                n_state = S_SU_EV;
            end
            S_SU_EV: begin
                nb_a = (r_row != '0) ? qa_k : KEY_MIN;
                nb_b = (r_col != '0) ? qb_k : KEY_MIN;
                we   = 1'b1;
                if ((r_key >= nb_a) && (r_key >= nb_b)) begin
                    wdata   = r_key;
                    n_state = S_FIN;
                end else if (nb_a > nb_b) begin
                    wdata   = nb_a;
                    n_row   = r_row - ROW_W'(1);
                    n_state = S_SU_RD;
                end else begin
                    wdata   = nb_b;
                    n_col   = r_col - COL_W'(1);
                    n_state = S_SU_RD;
                end
            end
            S_X0_RD: begin
                ra_addr = ADDR_FIRST;
                n_state = S_X0_EV;
            end
            S_X0_EV: begin
                n_value = qa_k;
                n_row   = '0;
                n_col   = '0;
                n_state = S_EX_RD;
            end
            S_EX_RD: begin
                ra_addr = cell_addr((r_row == ROW_W'(ROWS - 1)) ? r_row
                                                                : r_row + ROW_W'(1), r_col);
                rb_addr = cell_addr(r_row, (r_col == COL_W'(COLS - 1)) ? r_col
                                                                       : r_col + COL_W'(1));
                n_state = S_EX_EV;
            end
            S_EX_EV: begin
                nb_a = (r_row != ROW_W'(ROWS - 1)) ? qa_k : KEY_EMPTY;
                nb_b = (r_col != COL_W'(COLS - 1)) ? qb_k : KEY_EMPTY;
                we   = 1'b1;
                // hole is written empty only where the walk stops
                if ((nb_a == KEY_EMPTY) && (nb_b == KEY_EMPTY)) begin
                    wdata   = KEY_EMPTY;
                    n_state = S_FIN;
                end else if (nb_a < nb_b) begin
                    wdata   = nb_a;
                    n_row   = r_row + ROW_W'(1);
                    n_state = S_EX_RD;
                end else begin
                    wdata   = nb_b;
                    n_col   = r_col + COL_W'(1);
                    n_state = S_EX_RD;
                end
            end
            S_CT_RD: begin
                n_state = S_CT_EV;
            end
            S_CT_EV: begin
                if (r_key == qa_k) begin
                    n_found = 1'b1;
                    n_state = S_FIN;
                end else if (r_key < qa_k) begin
                    if (r_col == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_col   = r_col - COL_W'(1);
                        n_state = S_CT_RD;
                    end
                end else begin
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_row   = r_row + ROW_W'(1);
                        n_state = S_CT_RD;
                    end
                end
            end
            S_DK_RD: begin
                n_state = S_DK_EV;
            end
            S_DK_EV: begin
                if (r_key > qa_k) begin
                    n_status = ST_GREATER;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_SU_RD;
                end
            end
            S_FIN: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_vld     <= '0;
            r_va      <= 1'b0;
            r_vb      <= 1'b0;
            r_empty0  <= 1'b1;
            r_full    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_va    <= r_vld[ra_addr];
            r_vb    <= r_vld[rb_addr];
            if (we) begin
                r_vld[waddr] <= 1'b1;
                if (waddr == ADDR_FIRST) begin
                    r_empty0 <= (wdata == KEY_EMPTY);
                end
                if (waddr == ADDR_LAST) begin
                    r_full <= (wdata != KEY_EMPTY);
                end
            end
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_value  <= n_value;
        r_found  <= n_found;
        r_status <= n_status;
        if (out_load) begin
            r_o_value  <= r_value;
            r_o_found  <= r_found;
            r_o_status <= r_status;
            r_o_empty  <= r_empty0;
            r_o_full   <= r_full;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {3'b000, r_o_full, r_o_empty, r_o_status, r_o_found,
                              r_o_value};

    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_found) |-> (r_o_status == ST_OK && r_o_value == '0))
        else $error("found beat carries a status or a value");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_UNDERFLOW) |-> r_o_empty)
        else $error("underflow reported on a non-empty tableau");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_OVERFLOW) |-> r_o_full)
        else $error("overflow reported on a tableau that is not full");

endmodule
